/* hdl/sample_set_statistics_macros.svh */
// Assertion macros for the sample set statistics block.
// Used by the port checker; no other dependencies.
`ifndef SAMPLE_SET_STATISTICS_MACROS_SVH
`define SAMPLE_SET_STATISTICS_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sss_pkg.sv */
// Shared types and constants of the sample set statistics block.
// No dependencies.
package sss_pkg;

    // Fixed field widths of the item and result payloads
    localparam int IN_SAMPLE_W   = 24;
    localparam int COUNT_FIELD_W = 13;
    localparam int MEAN_FIELD_W  = 40;
    localparam int STD_FIELD_W   = 32;
    localparam int MEAN_FRAC     = 16;
    localparam int VAR_FRAC      = 16;
    localparam int SQRT_IN_W     = 64;
    localparam int SQRT_OUT_W    = 32;

    // Percentile ranks in per mille
    localparam int PCT_N      = 5;
    localparam int PCT_K_W    = 10;
    localparam int P999_MIN_N = 1000;
    localparam logic [PCT_K_W-1:0] PCT_K [PCT_N] =
        '{10'd500, 10'd900, 10'd950, 10'd990, 10'd999};

    // Divide by 1000 as multiply by ceil(2^38 / 1000) and shift; exact below 2^32
    localparam int PCT_RECIP = 274877907;
    localparam int PCT_SHIFT = 38;

    typedef struct packed {
        logic [IN_SAMPLE_W-1:0] sample;
        logic                   has_sample;
        logic                   last;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_FIELD_W-1:0] sample_count;
        logic [IN_SAMPLE_W-1:0]   minimum;
        logic [IN_SAMPLE_W-1:0]   maximum;
        logic [MEAN_FIELD_W-1:0]  mean_q16;
        logic [STD_FIELD_W-1:0]   std_dev_q8;
        logic [IN_SAMPLE_W-1:0]   pct50;
        logic [IN_SAMPLE_W-1:0]   pct90;
        logic [IN_SAMPLE_W-1:0]   pct95;
        logic [IN_SAMPLE_W-1:0]   pct99;
        logic [IN_SAMPLE_W-1:0]   pct999;
        logic                     overflowed;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_NS2,
        S_S1SQ,
        S_NN,
        S_VAR,
        S_SQRT,
        S_IDXM,
        S_IDXD,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_md_op;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_cmd;

endpackage

/* hdl/sss_stream_if.sv */
// Valid/ready stream interface carrying one payload item.
// Payload type is a parameter; no other dependencies.
interface sss_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

/* hdl/sss_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/sss_muldiv.sv */
// Shared bit-serial multiplier and restoring divider, one bit per cycle.
// Depends on sss_pkg.
module sss_muldiv import sss_pkg::*; #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_md_cmd      i_cmd,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_result
);
    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    t_md_op           r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_rem;
    logic [W:0]       rem_sh;
    logic             fits;

    // Shift in the next dividend bit and test the divisor against it
    assign rem_sh = {r_rem, r_a[W-1]};
    assign fits   = rem_sh >= {1'b0, r_b};

    // Control: busy for W steps, then a one-cycle done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift-add multiply or restoring divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end else begin
                r_a   <= r_a << 1;
                r_acc <= {r_acc[W-2:0], fits};
                r_rem <= fits ? W'(rem_sh - {1'b0, r_b}) : rem_sh[W-1:0];
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;
endmodule

/* hdl/sss_isqrt.sv */
// Sequential integer square root, two result bits per step pair, one step per cycle.
// Depends on sss_pkg.
module sss_isqrt import sss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SQRT_IN_W-1:0]  i_x,
    output logic                  o_done,
    output logic [SQRT_OUT_W-1:0] o_root
);
    logic                 r_busy;
    logic                 r_done;
    logic [SQRT_IN_W-1:0] r_x;
    logic [SQRT_IN_W-1:0] r_root;
    logic [SQRT_IN_W-1:0] r_bit;
    logic [SQRT_IN_W-1:0] trial;

    assign trial = r_root + r_bit;

    // Control: run until the test bit has shifted out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == SQRT_IN_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: subtract the trial value when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_root <= '0;
            r_bit  <= SQRT_IN_W'(1) << (SQRT_IN_W - 2);
        end else if (r_busy) begin
            if (r_x >= trial) begin
                r_x    <= r_x - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[SQRT_OUT_W-1:0];
endmodule

/* hdl/sample_set_statistics.sv */
// Sample set statistics: top level with sequencer, stats registers and radix select.
// Depends on sss_pkg, sss_stream_if, sss_ram, sss_muldiv and sss_isqrt.
//
// Samples load one per cycle into a RAM while count, sum, sum of squares, min and
// max update on the fly. An item with last set closes the set: input ready drops
// while the block runs mean, variance (shared serial multiply/divide, 15 operations
// of operand width AW = max(64, 2*SAMPLE_BITS + 2*clog2(DEPTH+1) + 16), 90 at the
// defaults; percentile indexes divide by 1000 through a reciprocal multiply), a
// square root, and a radix selection of all five percentiles that makes
// SAMPLE_BITS passes over the n stored samples through the RAM's single read
// port. An empty set skips all of this and goes straight to the output
// register. Overflowing samples are dropped and flagged. One output register
// holds the result, so loading of the next set can start while it waits to be
// taken.
module sample_set_statistics import sss_pkg::*; #(
    parameter int DEPTH       = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sss_stream_if.sink   i_item,
    sss_stream_if.source o_result
);
    localparam int SW     = SAMPLE_BITS;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int RAW    = $clog2(DEPTH);
    localparam int SUMW   = SW + CW;
    localparam int SQW    = 2 * SW + CW;
    localparam int NUM_W  = 2 * SW + 2 * CW + VAR_FRAC;
    localparam int AW     = (NUM_W > SQRT_IN_W) ? NUM_W : SQRT_IN_W;
    localparam int BIT_W  = $clog2(SW);
    localparam int LANE_W = $clog2(PCT_N);

    t_state              r_state, n_state;
    logic                r_launched;
    logic [CW-1:0]       r_count;
    logic [SUMW-1:0]     r_sum;
    logic [SQW-1:0]      r_sq_sum;
    logic [SW-1:0]       r_min;
    logic [SW-1:0]       r_max;
    logic                r_ovf;
    logic [AW-1:0]       r_prod_a;
    logic [AW-1:0]       r_prod_b;
    logic [AW-1:0]       r_nn;
    logic [MEAN_FIELD_W-1:0] r_mean;
    logic [SQRT_IN_W-1:0]    r_var;
    logic [SQRT_OUT_W-1:0]   r_std;
    logic [LANE_W-1:0]   r_lane;
    logic [CW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [BIT_W-1:0]    r_bit;
    logic [SW-1:0]       r_prefix [PCT_N];
    logic [CW-1:0]       r_rank [PCT_N];
    logic [CW-1:0]       r_cnt [PCT_N];
    t_out_item           r_out;
    logic                r_out_valid;

    logic                accept;
    logic                take;
    logic [SW-1:0]       s_in;
    logic [CW-1:0]       n_count;
    logic                pass_end;
    logic                out_load;
    logic [AW-1:0]       var_num;
    logic [SW-1:0]       rd_data;
    t_md_cmd             md_cmd;
    logic [AW-1:0]       md_a;
    logic [AW-1:0]       md_b;
    logic                md_done;
    logic [AW-1:0]       md_result;
    logic                sq_start;
    logic                sq_done;
    logic [SQRT_OUT_W-1:0] sq_root;

    // Input handshake and store decision
    assign i_item.ready = (r_state == S_IDLE);
    assign accept   = i_item.valid && i_item.ready;
    assign s_in     = SW'(i_item.data.sample);
    assign take     = accept && i_item.data.has_sample && (r_count < CW'(DEPTH));
    assign n_count  = r_count + CW'(take);
    assign pass_end = (r_addr == r_count) && !r_rd_vld;
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || o_result.ready);
    assign var_num  = (r_prod_a >= r_prod_b) ? ((r_prod_a - r_prod_b) << VAR_FRAC) : '0;

    sss_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (r_count[RAW-1:0]),
        .i_wdata (s_in),
        .i_raddr (r_addr[RAW-1:0]),
        .o_rdata (rd_data)
    );

    sss_muldiv #(
        .W (AW)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (md_cmd),
        .i_a      (md_a),
        .i_b      (md_b),
        .o_done   (md_done),
        .o_result (md_result)
    );

    sss_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (r_var),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit commands
    always_comb begin
        n_state      = r_state;
        md_cmd.start = 1'b0;
        md_cmd.op    = OP_MUL;
        md_a         = '0;
        md_b         = '0;
        sq_start     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_item.data.last) begin
                    n_state = (n_count == '0) ? S_FINISH : S_MEAN;
                end
            end
            S_MEAN: begin
                md_cmd.start = !r_launched;
                md_cmd.op    = OP_DIV;
                md_a         = AW'(r_sum) << MEAN_FRAC;
                md_b         = AW'(r_count);
                if (md_done) n_state = S_NS2;
            end
            S_NS2: begin
                md_cmd.start = !r_launched;
                md_a         = AW'(r_sq_sum);
                md_b         = AW'(r_count);
                if (md_done) n_state = S_S1SQ;
            end
            S_S1SQ: begin
                md_cmd.start = !r_launched;
                md_a         = AW'(r_sum);
                md_b         = AW'(r_sum);
                if (md_done) n_state = S_NN;
            end
            S_NN: begin
                md_cmd.start = !r_launched;
                md_a         = AW'(r_count);
                md_b         = AW'(r_count);
                if (md_done) n_state = S_VAR;
            end
            S_VAR: begin
                md_cmd.start = !r_launched;
                md_cmd.op    = OP_DIV;
                md_a         = var_num;
                md_b         = r_nn;
                if (md_done) n_state = S_SQRT;
            end
            S_SQRT: begin
                sq_start = !r_launched;
                if (sq_done) n_state = S_IDXM;
            end
            S_IDXM: begin
                md_cmd.start = !r_launched;
                md_a         = AW'(r_count);
                md_b         = AW'(PCT_K[r_lane]);
                if (md_done) n_state = S_IDXD;
            end
            S_IDXD: begin
                // Scale by the reciprocal of 1000; the shift follows at the latch
                md_cmd.start = !r_launched;
                md_a         = r_prod_a;
                md_b         = AW'(PCT_RECIP);
                if (md_done) begin
                    n_state = (r_lane == LANE_W'(PCT_N - 1)) ? S_SCAN : S_IDXM;
                end
            end
            S_SCAN: begin
                if (pass_end && r_bit == '0) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Track whether the current unit operation has been started
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launched <= 1'b0;
        end else if (md_done || sq_done) begin
            r_launched <= 1'b0;
        end else if (md_cmd.start || sq_start) begin
            r_launched <= 1'b1;
        end
    end

    // Running statistics: update on stored samples, flag dropped ones, clear at set end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || out_load) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_sq_sum <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_ovf    <= 1'b0;
        end else if (accept && i_item.data.has_sample) begin
            if (take) begin
                r_count  <= n_count;
                r_sum    <= r_sum + SUMW'(s_in);
                r_sq_sum <= r_sq_sum + SQW'(s_in * s_in);
                if (s_in < r_min) r_min <= s_in;
                if (s_in > r_max) r_max <= s_in;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Latch unit results
    always_ff @(posedge i_clk) begin
        if (r_state == S_SQRT && sq_done) begin
            r_std <= sq_root;
        end
        if (md_done) begin
            case (r_state)
                S_MEAN: r_mean <= MEAN_FIELD_W'(md_result);
                S_NS2:  r_prod_a <= md_result;
                S_S1SQ: r_prod_b <= md_result;
                S_NN:   r_nn <= md_result;
                S_VAR:  r_var <= ((md_result >> SQRT_IN_W) != '0) ? '1
                                                                  : SQRT_IN_W'(md_result);
                S_IDXM: r_prod_a <= md_result;
                default: ;
            endcase
        end
    end

    // Percentile lane index
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_lane <= '0;
        end else if (r_state == S_IDXD && md_done) begin
            r_lane <= r_lane + 1'b1;
        end
    end

    // Radix select: count matches per pass, then fix one bit per lane
    always_ff @(posedge i_clk) begin
        if (r_state != S_SCAN) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_bit    <= BIT_W'(SW - 1);
        end else if (pass_end) begin
            r_addr <= '0;
            r_bit  <= r_bit - 1'b1;
        end else begin
            r_rd_vld <= (r_addr != r_count);
            if (r_addr != r_count) r_addr <= r_addr + 1'b1;
        end
        for (int p = 0; p < PCT_N; p++) begin
            if (r_state == S_IDXD && md_done && r_lane == LANE_W'(p)) begin
                r_rank[p]   <= CW'(md_result >> PCT_SHIFT);
                r_prefix[p] <= '0;
                r_cnt[p]    <= '0;
            end else if (r_state == S_SCAN) begin
                if (pass_end) begin
                    r_cnt[p] <= '0;
                    if (r_rank[p] >= r_cnt[p]) begin
                        r_prefix[p] <= r_prefix[p] | (SW'(1) << r_bit);
                        r_rank[p]   <= r_rank[p] - r_cnt[p];
                    end
                end else if (r_rd_vld && ((rd_data >> r_bit) == (r_prefix[p] >> r_bit))) begin
                    r_cnt[p] <= r_cnt[p] + 1'b1;
                end
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_count == '0) begin
                r_out <= '0;
            end else begin
                r_out.sample_count <= COUNT_FIELD_W'(r_count);
                r_out.minimum      <= IN_SAMPLE_W'(r_min);
                r_out.maximum      <= IN_SAMPLE_W'(r_max);
                r_out.mean_q16     <= r_mean;
                r_out.std_dev_q8   <= r_std;
                r_out.pct50        <= IN_SAMPLE_W'(r_prefix[0]);
                r_out.pct90        <= IN_SAMPLE_W'(r_prefix[1]);
                r_out.pct95        <= IN_SAMPLE_W'(r_prefix[2]);
                r_out.pct99        <= IN_SAMPLE_W'(r_prefix[3]);
                r_out.pct999       <= (32'(r_count) >= P999_MIN_N)
                                      ? IN_SAMPLE_W'(r_prefix[4]) : IN_SAMPLE_W'(r_max);
                r_out.overflowed   <= r_ovf;
            end
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
endmodule

/* hdl/sss_checker.sv */
// Port-level checker for the sample set statistics block, bound to the top level.
// Depends on sss_pkg and sample_set_statistics_macros.svh.
`include "sample_set_statistics_macros.svh"

module sss_checker import sss_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_item_valid,
    input logic      i_item_ready,
    input t_in_item  i_item_data,
    input logic      i_result_valid,
    input logic      i_result_ready,
    input t_out_item i_result_data
);
    // A waiting result holds its payload
    `SSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_result_valid && !i_result_ready, i_result_valid && $stable(i_result_data), "result dropped or changed while stalled")

    // Closing an item stops intake while the set is evaluated
    `SSS_ASSERT_NEXT(a_close_stall, i_clk, i_rst_n, i_item_valid && i_item_ready && i_item_data.last, !i_item_ready, "input taken right after a closing item")

    // An empty set reports zeros in min, max, mean, median and the overflow flag
    `SSS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_result_valid && i_result_data.sample_count == '0, i_result_data.minimum == '0 && i_result_data.maximum == '0 && i_result_data.mean_q16 == '0 && i_result_data.pct50 == '0 && i_result_data.overflowed == 1'b0, "empty set result not zero")

    // Order statistics are monotonic between min and max
    `SSS_ASSERT_NOW(a_pct_order, i_clk, i_rst_n, i_result_valid && i_result_data.sample_count != '0, i_result_data.minimum <= i_result_data.pct50 && i_result_data.pct50 <= i_result_data.pct90 && i_result_data.pct90 <= i_result_data.pct95 && i_result_data.pct95 <= i_result_data.pct99 && i_result_data.pct99 <= i_result_data.pct999 && i_result_data.pct999 <= i_result_data.maximum, "percentiles out of order")
endmodule

bind sample_set_statistics sss_checker u_sss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_item_valid   (i_item.valid),
    .i_item_ready   (i_item.ready),
    .i_item_data    (i_item.data),
    .i_result_valid (o_result.valid),
    .i_result_ready (o_result.ready),
    .i_result_data  (o_result.data)
);
